/* src/sts_pkg.sv */
// Shared types and constants for the Taylor series sine unit.
// Holds the 1/(2n+1)! coefficient table; no dependencies.
package sts_pkg;

	localparam int ANG_W         = 20;
	localparam int ACC_W         = 64;
	localparam int MAG_W         = 63;
	localparam int ACC_FRAC      = 58;
	localparam int X2_W          = 39;
	localparam int XM_W          = 20;
	localparam int MAX_TERMS     = 10;
	localparam int NUM_TERMS_DEF = 7;
	localparam int FRAC_BITS_DEF = 17;

	// round(2^58 / (2n+1)!), n = 0 .. MAX_TERMS-1
	localparam logic [ACC_W-1:0] COEF [MAX_TERMS] = '{
		64'd288230376151711744,
		64'd48038396025285291,
		64'd2401919801264265,
		64'd57188566696768,
		64'd794285648566,
		64'd7220778623,
		64'd46287042,
		64'd220414,
		64'd810,
		64'd2
	};

	// angle operands carried alongside the accumulator
	typedef struct packed {
		logic [X2_W-1:0] x2;
		logic [XM_W-1:0] mag;
		logic            neg;
	} xarg_t;

endpackage

/* src/sts_mulsh.sv */
// Four-stage signed 64-bit by unsigned magnitude multiply with rounded shift and saturation.
// Split into 32 x B_W/2 partial products; depends on sts_pkg.
module sts_mulsh #(
	parameter int B_W   = 39,
	parameter int SHIFT = 34
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic signed [sts_pkg::ACC_W-1:0] s,
	input  logic [B_W-1:0]                  b,
	input  logic                            b_neg,
	output logic                            out_valid,
	output logic [sts_pkg::MAG_W-1:0]       mag,
	output logic                            neg
);
	import sts_pkg::*;

	localparam int BL  = (B_W + 1) / 2;
	localparam int BH  = B_W - BL;
	localparam int P_W = MAG_W + B_W;
	localparam logic [P_W:0] HALF = (P_W + 1)'(1) << (SHIFT - 1);

	logic                   valid_s1, valid_s2, valid_s3, valid_s4;
	logic [MAG_W-1:0]       a_s1;
	logic [B_W-1:0]         b_s1;
	logic                   neg_s1, neg_s2, neg_s3, neg_s4;
	logic [32+BL-1:0]       pp00_s2;
	logic [32+BH-1:0]       pp01_s2;
	logic [31+BL-1:0]       pp10_s2;
	logic [31+BH-1:0]       pp11_s2;
	logic [P_W-1:0]         full_s3;
	logic [MAG_W-1:0]       mag_s4;

	logic [ACC_W-1:0]       s_inv;
	logic [MAG_W-1:0]       a_abs;
	logic [P_W-1:0]         full_d;
	logic [P_W:0]           rnd;
	logic [P_W:0]           shf;

	assign s_inv = -s;
	assign a_abs = s[ACC_W-1] ? s_inv[MAG_W-1:0] : s[MAG_W-1:0];

	assign full_d = P_W'(pp00_s2)
		+ (P_W'(pp01_s2) << BL)
		+ (P_W'(pp10_s2) << 32)
		+ (P_W'(pp11_s2) << (32 + BL));

	assign rnd = {1'b0, full_s3} + HALF;
	assign shf = rnd >> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a_abs;
			b_s1    <= b;
			neg_s1  <= s[ACC_W-1] ^ b_neg;
			pp00_s2 <= a_s1[31:0] * b_s1[BL-1:0];
			pp01_s2 <= a_s1[31:0] * b_s1[B_W-1:BL];
			pp10_s2 <= a_s1[MAG_W-1:32] * b_s1[BL-1:0];
			pp11_s2 <= a_s1[MAG_W-1:32] * b_s1[B_W-1:BL];
			neg_s2  <= neg_s1;
			full_s3 <= full_d;
			neg_s3  <= neg_s2;
			mag_s4  <= (|shf[P_W:MAG_W]) ? {MAG_W{1'b1}} : shf[MAG_W-1:0];
			neg_s4  <= neg_s3;
		end
	end

	assign out_valid = valid_s4;
	assign mag       = mag_s4;
	assign neg       = neg_s4;

endmodule

/* src/sts_step.sv */
// One Horner step: s' = c - round(s * x^2 >> 2*FRAC_BITS), saturated.
// Five stages; uses sts_mulsh and sts_pkg.
module sts_step #(
	parameter int IDX       = 0,
	parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic signed [sts_pkg::ACC_W-1:0] in_s,
	input  sts_pkg::xarg_t                   in_x,
	output logic                             out_valid,
	output logic signed [sts_pkg::ACC_W-1:0] out_s,
	output sts_pkg::xarg_t                   out_x
);
	import sts_pkg::*;

	localparam logic signed [ACC_W+1:0] C_EXT = {2'b00, COEF[IDX]};
	localparam logic signed [ACC_W+1:0] S_MAX = {3'b000, {MAG_W{1'b1}}};

	logic             m_valid;
	logic [MAG_W-1:0] m_mag;
	logic             m_neg;
	xarg_t            side_s1, side_s2, side_s3, side_s4, x_s5;
	logic             valid_s5;
	logic signed [ACC_W-1:0] s_s5;
	logic signed [ACC_W+1:0] mag_ext, diff;

	sts_mulsh #(
		.B_W   (X2_W),
		.SHIFT (2 * FRAC_BITS)
	) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.s         (in_s),
		.b         (in_x.x2),
		.b_neg     (1'b0),
		.out_valid (m_valid),
		.mag       (m_mag),
		.neg       (m_neg)
	);

	assign mag_ext = {3'b000, m_mag};
	assign diff    = m_neg ? (C_EXT + mag_ext) : (C_EXT - mag_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s5 <= 1'b0;
		else if (en)
			valid_s5 <= m_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_x;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			x_s5    <= side_s4;
			s_s5    <= (diff > S_MAX) ? S_MAX[ACC_W-1:0] : diff[ACC_W-1:0];
		end
	end

	assign out_valid = valid_s5;
	assign out_s     = s_s5;
	assign out_x     = x_s5;

endmodule

/* src/sine_taylor_series_unit.sv */
// Top level of the Taylor series sine unit: input register, x^2 stage, Horner chain,
// final multiply by x and output saturation. Uses sts_pkg, sts_step, sts_mulsh.
//
//   channel | direction | payload       | handshake
//   angle   | in        | Q2.17, 20 bit | angle_valid / angle_stall
//   sine    | out       | Q2.17, 20 bit | sine_valid / sine_stall
//
// One beat per cycle sustained unless a held sine beat is stalled. A beat passes the input
// register, the x^2 register, the Horner steps, the final multiply and the output register.
// Reset clears only the valid bits. A stalled sine beat freezes the whole
// pipeline, so angle_stall follows sine_stall while a result is held.
module sine_taylor_series_unit #(
	parameter int NUM_TERMS = sts_pkg::NUM_TERMS_DEF,
	parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             angle_valid,
	output logic                             angle_stall,
	input  logic signed [sts_pkg::ANG_W-1:0] angle,
	output logic                             sine_valid,
	input  logic                             sine_stall,
	output logic signed [sts_pkg::ANG_W-1:0] sine
);
	import sts_pkg::*;

	localparam int NSTEP = NUM_TERMS - 1;
	localparam logic [MAG_W-1:0] LIM_POS = MAG_W'(2 ** (ANG_W - 1) - 1);
	localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(2 ** (ANG_W - 1));
	localparam logic signed [ANG_W-1:0] OUT_MAX = {1'b0, {(ANG_W-1){1'b1}}};
	localparam logic signed [ANG_W-1:0] OUT_MIN = {1'b1, {(ANG_W-1){1'b0}}};

	logic                    en;
	logic                    valid_s1, valid_s2;
	logic signed [ANG_W-1:0] ang_s1;
	xarg_t                   x_s2;
	logic signed [2*ANG_W-1:0] sq;
	logic [ANG_W-1:0]        ang_inv;

	logic                    v_ch [NUM_TERMS];
	logic signed [ACC_W-1:0] s_ch [NUM_TERMS];
	xarg_t                   x_ch [NUM_TERMS];

	logic                    f_valid;
	logic [MAG_W-1:0]        f_mag;
	logic                    f_neg;
	logic [MAG_W:0]          f_inv;
	logic signed [ANG_W-1:0] sine_d;
	logic                    sine_valid_q;
	logic signed [ANG_W-1:0] sine_q;

	assign en          = !(sine_valid_q && sine_stall);
	assign angle_stall = !en;

	assign sq      = ang_s1 * ang_s1;
	assign ang_inv = -ang_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= angle_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1   <= angle;
			x_s2.x2  <= sq[X2_W-1:0];
			x_s2.mag <= ang_s1[ANG_W-1] ? ang_inv : ang_s1;
			x_s2.neg <= ang_s1[ANG_W-1];
		end
	end

	assign v_ch[0] = valid_s2;
	assign s_ch[0] = COEF[NUM_TERMS-1];
	assign x_ch[0] = x_s2;

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		sts_step #(
			.IDX       (NUM_TERMS - 2 - k),
			.FRAC_BITS (FRAC_BITS)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_ch[k]),
			.in_s      (s_ch[k]),
			.in_x      (x_ch[k]),
			.out_valid (v_ch[k+1]),
			.out_s     (s_ch[k+1]),
			.out_x     (x_ch[k+1])
		);
	end

	sts_mulsh #(
		.B_W   (XM_W),
		.SHIFT (ACC_FRAC)
	) u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_ch[NSTEP]),
		.s         (s_ch[NSTEP]),
		.b         (x_ch[NSTEP].mag),
		.b_neg     (x_ch[NSTEP].neg),
		.out_valid (f_valid),
		.mag       (f_mag),
		.neg       (f_neg)
	);

	assign f_inv = -{1'b0, f_mag};

	always_comb begin
		if (f_neg)
			sine_d = (f_mag > LIM_NEG) ? OUT_MIN : f_inv[ANG_W-1:0];
		else
			sine_d = (f_mag > LIM_POS) ? OUT_MAX : f_mag[ANG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sine_valid_q <= 1'b0;
		else if (en)
			sine_valid_q <= f_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			sine_q <= sine_d;
	end

	assign sine_valid = sine_valid_q;
	assign sine       = sine_q;

endmodule

/* bench/tb_sine_taylor_series_unit.sv */
// Testbench for sine_taylor_series_unit: directed and random Q2.17 angles checked
// against an in-bench fixed-point Taylor series predictor. Needs sts_pkg and the RTL.
`timescale 1ns / 1ps

module tb_sine_taylor_series_unit;

	localparam int W         = sts_pkg::ANG_W;
	localparam int NT        = 7;
	localparam int FB        = 17;
	localparam int TERMS     = (NT > 10) ? 10 : ((NT < 1) ? 1 : NT);
	localparam int ACC_FRAC  = 58;
	localparam int LATENCY   = 2 + 5 * (TERMS - 1) + 4 + 1;
	localparam int N_RANDOM  = 500;
	localparam int MAX_CYC   = 300000;
	localparam int IDLE_PCT  = 33;
	localparam int SIG_CLIP  = 411775;
	localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic signed [W-1:0] angle;
		logic signed [W-1:0] sine;
	} sine_pair_t;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                angle_valid = 1'b0;
	logic                angle_stall;
	logic signed [W-1:0] angle       = '0;
	logic                sine_valid;
	logic                sine_stall  = 1'b0;
	logic signed [W-1:0] sine;

	logic signed [W-1:0] angle_pending_q[$];
	sine_pair_t          sine_expected_q[$];
	logic                angle_taken = 1'b0;
	int                  n_angles    = 0;
	int                  n_directed  = 0;
	int                  n_sines     = 0;
	int                  err_count   = 0;
	int                  cycles      = 0;

	sine_taylor_series_unit #(
		.NUM_TERMS(NT),
		.FRAC_BITS(FB)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.angle_valid(angle_valid),
		.angle_stall(angle_stall),
		.angle(angle),
		.sine_valid(sine_valid),
		.sine_stall(sine_stall),
		.sine(sine)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// round(2^58 / (2n+1)!)
	function automatic longint series_coef(int n);
		bit [63:0] f;
		f = 64'd1;
		for (int k = 2; k <= 2 * n + 1; k++)
			f = f * k;
		return longint'(((64'd1 << ACC_FRAC) + f / 2) / f);
	endfunction

	// a*b with its magnitude rounded half away, shifted right by sh, clipped to +-(2^63-1)
	function automatic longint mul_round(longint a, longint b, int sh);
		bit         neg;
		bit [63:0]  ma, mb, mag;
		bit [127:0] p;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? -a : a;
		mb  = (b < 0) ? -b : b;
		p   = {64'd0, ma} * {64'd0, mb};
		if (sh != 0)
			p = (p + (128'd1 << (sh - 1))) >> sh;
		mag = (p[127:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic signed [W-1:0] sine_series(logic signed [W-1:0] ang);
		longint x, x2, acc, c, p, y;
		x   = ang;
		x2  = x * x;
		acc = series_coef(TERMS - 1);
		for (int n = TERMS - 2; n >= 0; n--) begin
			c = series_coef(n);
			p = mul_round(acc, x2, 2 * FB);
			if (p < 0 && c > I64_MAX + p)
				acc = I64_MAX;
			else
				acc = c - p;
		end
		y = mul_round(acc, x, ACC_FRAC);
		if (y > 524287)
			y = 524287;
		if (y < -524288)
			y = -524288;
		return y[W-1:0];
	endfunction

	task automatic report_mismatch(string msg);
		err_count++;
		$display("mismatch @%0t: %s", $realtime, msg);
	endtask

	// quiet window: no idling on either side
	function automatic bit take_idle();
		if (n_angles >= 100 && n_angles < 260)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		angle_taken <= arst_n && angle_valid && !angle_stall;
		if (arst_n && angle_valid && !angle_stall) begin
			sine_expected_q.push_back('{angle: angle, sine: sine_series(angle)});
			n_angles <= n_angles + 1;
		end
		if (arst_n && sine_valid && !sine_stall) begin
			n_sines <= n_sines + 1;
			if (sine_expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected sine beat %0d", sine));
			end else begin
				sine_pair_t e;
				e = sine_expected_q.pop_front();
				if (sine !== e.sine)
					report_mismatch($sformatf("angle %0d: sine %0d, expected %0d",
						e.angle, sine, e.sine));
			end
		end
		if (cycles > MAX_CYC) begin
			$display("timeout after %0d cycles, %0d sines outstanding",
				cycles, sine_expected_q.size());
			$display("[sine_taylor_series_unit] ERROR");
			$finish;
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (!angle_valid || angle_taken)) begin
			if (angle_pending_q.size() > 0 && !take_idle()) begin
				angle_valid <= 1'b1;
				angle       <= angle_pending_q.pop_front();
			end else begin
				angle_valid <= 1'b0;
			end
		end
	end

	// sink
	always @(negedge clk) begin
		if (arst_n)
			sine_stall <= take_idle();
	end

	initial begin
		int d[$];
		d = '{0, 1, -1, 524287, -524288, 205887, -205887, 411775, -411775,
			102944, -102944, 131072, -131072, 262144, -262144, 349525, -349526,
			3, 400000, -400000, 500000, -500000};
		foreach (d[i])
			angle_pending_q.push_back(d[i][W-1:0]);
		n_directed = d.size();
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(99) < 70)
				angle_pending_q.push_back(W'($signed($urandom_range(2 * SIG_CLIP)) - SIG_CLIP));
			else
				angle_pending_q.push_back(W'($urandom));
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (angle_pending_q.size() != 0 || angle_valid)
			@(posedge clk);
		while (sine_expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		if (sine_expected_q.size() != 0)
			report_mismatch($sformatf("%0d sines never arrived", sine_expected_q.size()));
		$display("covered %0d angles (%0d directed, rest random), %0d sines checked",
			n_angles, n_directed, n_sines);
		$display("%0d mismatches, %0d cycles", err_count, cycles);
		if (err_count == 0)
			$display("[sine_taylor_series_unit] OK");
		else
			$display("[sine_taylor_series_unit] ERROR");
		$finish;
	end

endmodule
